@@ hw/rtl/lfp_pkg.sv @@
// shared types and constants of the lidar frame parser
package lfp_pkg;

    localparam int HDR_LEN = 16;

    // result kinds
    localparam logic [1:0] KIND_POINT  = 2'd0;
    localparam logic [1:0] KIND_HEADER = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    // result status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_PREAMBLE = 3'd1;
    localparam logic [2:0] ST_DEVICE   = 3'd2;
    localparam logic [2:0] ST_FRAME    = 3'd3;
    localparam logic [2:0] ST_TRUNC    = 3'd4;
    localparam logic [2:0] ST_TOO_MANY = 3'd5;

    // configuration register indexes
    localparam logic [1:0] CFG_PREAMBLE = 2'd0;
    localparam logic [1:0] CFG_DEVICE   = 2'd1;
    localparam logic [1:0] CFG_FRAME    = 2'd2;

    typedef struct packed {
        logic [15:0] preamble;
        logic [3:0]  device;
        logic [3:0]  frame;
    } cfg_t;

    // one request from the byte front end to the result back end
    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  status;
        logic        trunc;       // truncated error follows this result
        logic [8:0]  index;
        logic [15:0] intensity;
        logic [15:0] range_mm;
        logic [7:0]  step_byte;
        logic        first;
        logic        last;
        logic [3:0]  head;
        logic [3:0]  frame_no;
        logic [9:0]  count;
        logic [31:0] ts;
        logic [15:0] start_ang;
        logic [15:0] stop_ang;
        logic [15:0] divisor;
        logic        fmt0;
        logic        div_en;
    } cmd_t;

endpackage

@@ hw/rtl/lfp_front.sv @@
// byte front end: header capture, checks, record assembly
module lfp_front #(
    parameter int MAX_POINTS = 512
) (
    input  logic          clk,
    input  logic          rst_n,
    input  lfp_pkg::cfg_t cfg,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,
    input  logic          s_tlast,
    input  logic          q_full,
    output logic          push,
    output lfp_pkg::cmd_t cmd
);
    import lfp_pkg::*;

    localparam int PDW = $clog2(MAX_POINTS + 1);
    localparam logic [15:0] MAXP = 16'(MAX_POINTS);

    logic [6:0]     pos_reg, pos_next;
    logic [PDW-1:0] pd_reg, pd_next;
    logic           disc_reg, disc_next;
    logic [7:0]     hdr_reg [HDR_LEN];
    logic [7:0]     rec0_reg, rec1_reg, rec2_reg;

    logic        accept, main_v, disc_set;
    logic [15:0] cnt, limit16;
    logic [6:0]  ds, off;
    logic [4:0]  code_p1;
    logic [16:0] pd_plus;
    logic [7:0]  b;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && !q_full;
    assign b        = s_tdata;
    assign cnt      = {hdr_reg[12], hdr_reg[13]};
    assign limit16  = (cnt > MAXP) ? MAXP : cnt;
    assign code_p1  = {1'b0, hdr_reg[3][7:4]} + 5'd1;
    assign ds       = ({code_p1, 2'b00} < 7'(HDR_LEN)) ? 7'(HDR_LEN) : {code_p1, 2'b00};
    assign off      = pos_reg - ds;
    assign pd_plus  = 17'(pd_reg) + 17'd1;

    always_comb
    begin
        pos_next = pos_reg;
        pd_next  = pd_reg;
        disc_set = 1'b0;
        main_v   = 1'b0;
        cmd      = '0;
        if (!disc_reg)
        begin
            if (pos_reg < 7'(HDR_LEN))
            begin
                pos_next = pos_reg + 7'd1;
                if (pos_reg == 7'd1 && {hdr_reg[0], b} != cfg.preamble)
                begin
                    main_v = 1'b1; disc_set = 1'b1;
                    cmd.kind = KIND_ERROR; cmd.status = ST_PREAMBLE;
                end
                else if (pos_reg == 7'd2 && b[7:4] != cfg.device)
                begin
                    main_v = 1'b1; disc_set = 1'b1;
                    cmd.kind = KIND_ERROR; cmd.status = ST_DEVICE;
                end
                else if (pos_reg == 7'd2 && b[3:0] != cfg.frame)
                begin
                    main_v = 1'b1; disc_set = 1'b1;
                    cmd.kind = KIND_ERROR; cmd.status = ST_FRAME;
                end
                else if (pos_reg == 7'(HDR_LEN - 1))
                begin
                    main_v        = 1'b1;
                    cmd.kind      = KIND_HEADER;
                    cmd.status    = (cnt > MAXP) ? ST_TOO_MANY : ST_OK;
                    cmd.head      = hdr_reg[8][7:4];
                    cmd.frame_no  = hdr_reg[3][3:0];
                    cmd.count     = 10'(limit16);
                    cmd.ts        = {hdr_reg[4], hdr_reg[5], hdr_reg[6], hdr_reg[7]};
                    cmd.start_ang = {hdr_reg[10], hdr_reg[11]};
                    cmd.stop_ang  = {hdr_reg[14], b};
                    cmd.divisor   = cnt - 16'd1;
                    cmd.fmt0      = (hdr_reg[8][3:0] == 4'd0);
                    cmd.div_en    = (hdr_reg[8][3:0] == 4'd0) && (cnt > 16'd1);
                    pd_next       = '0;
                    disc_set      = (limit16 == 16'd0);
                end
            end
            else if (pos_reg < ds)
            begin
                pos_next = pos_reg + 7'd1;
            end
            else if (off < 7'd3)
            begin
                pos_next = pos_reg + 7'd1;
            end
            else
            begin
                main_v        = 1'b1;
                cmd.kind      = KIND_POINT;
                cmd.status    = ST_OK;
                cmd.index     = 9'(pd_reg);
                cmd.intensity = (hdr_reg[8][3:0] == 4'd0) ? {rec0_reg, rec1_reg}
                                                          : {8'd0, rec0_reg};
                cmd.range_mm  = {rec2_reg, b};
                cmd.step_byte = rec1_reg;
                cmd.first     = (pd_reg == '0);
                cmd.last      = (pd_plus >= {1'b0, limit16});
                pd_next       = PDW'(pd_plus);
                pos_next      = ds;
                disc_set      = (pd_plus >= {1'b0, limit16});
            end
        end
        disc_next = disc_reg || disc_set;
        if (s_tlast)
        begin
            pos_next  = '0;
            pd_next   = '0;
            disc_next = 1'b0;
            if (!(disc_reg || disc_set))
            begin
                if (main_v)
                    cmd.trunc = 1'b1;
                else
                begin
                    main_v     = 1'b1;
                    cmd.kind   = KIND_ERROR;
                    cmd.status = ST_TRUNC;
                end
            end
        end
    end

    assign push = accept && main_v;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            pd_reg   <= '0;
            disc_reg <= 1'b0;
        end
        else if (accept)
        begin
            pos_reg  <= pos_next;
            pd_reg   <= pd_next;
            disc_reg <= disc_next;
        end
    end

    // header and record bytes, payload only
    always_ff @(posedge clk)
    begin
        if (accept && !disc_reg)
        begin
            if (pos_reg < 7'(HDR_LEN))
                hdr_reg[pos_reg[3:0]] <= b;
            else if (pos_reg >= ds)
            begin
                case (off)
                    7'd0:    rec0_reg <= b;
                    7'd1:    rec1_reg <= b;
                    7'd2:    rec2_reg <= b;
                    default: ;
                endcase
            end
        end
    end

endmodule

@@ hw/rtl/lfp_queue.sv @@
// short request queue between front and back end
module lfp_queue #(
    parameter int DEPTH = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  lfp_pkg::cmd_t din,
    input  logic          pop,
    output lfp_pkg::cmd_t dout,
    output logic          not_empty,
    output logic          full
);
    import lfp_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t          mem [DEPTH];
    logic [PW-1:0] wr_reg, rd_reg;
    logic [CW-1:0] cnt_reg;
    logic          do_push, do_pop;

    assign full      = (cnt_reg == CW'(DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign dout      = mem[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push)
                wr_reg <= (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + PW'(1);
            if (do_pop)
                rd_reg <= (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + PW'(1);
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + CW'(1);
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_reg] <= din;
    end

endmodule

@@ hw/rtl/lfp_back.sv @@
// result back end: angle step divider, angle accumulation, output register
module lfp_back #(
    parameter int ANGLE_FRAC_BITS = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  lfp_pkg::cmd_t cmd,
    input  logic          cmd_valid,
    output logic          cmd_pop,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [127:0]  m_tdata,
    output logic [1:0]    m_tuser,
    output logic          m_tlast
);
    import lfp_pkg::*;

    localparam int AW = 16 + ANGLE_FRAC_BITS;
    localparam int CW = $clog2(AW + 1);
    localparam logic [AW-1:0] FULL_TURN = AW'(64'd36000 << ANGLE_FRAC_BITS);

    typedef enum logic [1:0] {S_RUN, S_DIV, S_FIX} state_t;

    typedef struct packed {
        logic [2:0]  pad;
        logic [38:0] ts;
        logic [9:0]  count;
        logic [3:0]  frame_no;
        logic [3:0]  head;
        logic [23:0] angle;
        logic [15:0] range_mm;
        logic [15:0] intensity;
        logic [8:0]  index;
        logic [2:0]  status;
    } res_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [15:0]   rem_reg, rem_next, dvs_reg, dvs_next;
    logic [AW-1:0] quo_reg, quo_next, acc_reg, acc_next, step_reg, step_next;
    logic          neg_reg, neg_next, fmt0_reg, fmt0_next;
    logic          tp_reg, tp_next, ov_reg, ov_next, last_reg, last_next;
    logic [1:0]    kind_reg, kind_next;
    res_t          res_reg, res_next;
    logic [3:0]    head_reg, head_next, fno_reg, fno_next;
    logic [9:0]    count_reg, count_next;
    logic [38:0]   ts_reg, ts_next;

    logic          can_load;
    logic [16:0]   rem_sh, diff;
    logic          ge;
    logic [AW-1:0] red, start_sh, add, wrapped, ang, mag_sh;
    logic [AW:0]   sum;
    logic [15:0]   mag;
    logic [38:0]   ts100;

    assign can_load = !ov_reg || m_tready;
    assign cmd_pop  = (state_reg == S_RUN) && !tp_reg && can_load && cmd_valid;

    // restoring division step, one quotient bit per cycle
    assign rem_sh = {rem_reg, quo_reg[AW-1]};
    assign ge     = rem_sh >= {1'b0, dvs_reg};
    assign red    = (quo_reg >= FULL_TURN) ? quo_reg - FULL_TURN : quo_reg;

    assign start_sh = AW'(cmd.start_ang) << ANGLE_FRAC_BITS;
    assign diff     = {1'b0, cmd.stop_ang} - {1'b0, cmd.start_ang};
    assign mag      = diff[16] ? 16'(-diff) : diff[15:0];
    assign mag_sh   = AW'(mag) << ANGLE_FRAC_BITS;
    assign ts100    = 39'(cmd.ts) * 39'd100;

    assign add     = fmt0_reg ? step_reg : (AW'(cmd.step_byte) << ANGLE_FRAC_BITS);
    assign sum     = {1'b0, acc_reg} + {1'b0, add};
    assign wrapped = (sum >= {1'b0, FULL_TURN}) ? AW'(sum - {1'b0, FULL_TURN}) : sum[AW-1:0];
    assign ang     = cmd.first ? acc_reg : wrapped;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        dvs_next   = dvs_reg;
        quo_next   = quo_reg;
        acc_next   = acc_reg;
        step_next  = step_reg;
        neg_next   = neg_reg;
        fmt0_next  = fmt0_reg;
        head_next  = head_reg;
        fno_next   = fno_reg;
        count_next = count_reg;
        ts_next    = ts_reg;
        tp_next    = tp_reg;
        ov_next    = ov_reg && !m_tready;
        kind_next  = kind_reg;
        last_next  = last_reg;
        res_next   = res_reg;

        unique case (state_reg)
            S_DIV:
            begin
                rem_next = ge ? 16'(rem_sh - {1'b0, dvs_reg}) : rem_sh[15:0];
                quo_next = {quo_reg[AW-2:0], ge};
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                    state_next = S_FIX;
            end
            S_FIX:
            begin
                step_next  = (neg_reg && red != '0) ? FULL_TURN - red : red;
                state_next = S_RUN;
            end
            default: ;
        endcase

        if (tp_reg && can_load)
        begin
            ov_next   = 1'b1;
            tp_next   = 1'b0;
            kind_next = KIND_ERROR;
            last_next = 1'b0;
            res_next  = '0;
            res_next.status = ST_TRUNC;
        end
        else if (cmd_pop)
        begin
            ov_next   = 1'b1;
            tp_next   = cmd.trunc;
            kind_next = cmd.kind;
            last_next = 1'b0;
            res_next  = '0;
            res_next.status = cmd.status;
            case (cmd.kind)
                KIND_HEADER:
                begin
                    head_next  = cmd.head;
                    fno_next   = cmd.frame_no;
                    count_next = cmd.count;
                    ts_next    = ts100;
                    fmt0_next  = cmd.fmt0;
                    acc_next   = (start_sh >= FULL_TURN) ? start_sh - FULL_TURN : start_sh;
                    step_next  = '0;
                    res_next.head     = cmd.head;
                    res_next.frame_no = cmd.frame_no;
                    res_next.count    = cmd.count;
                    res_next.ts       = ts100;
                    if (cmd.div_en)
                    begin
                        rem_next   = '0;
                        dvs_next   = cmd.divisor;
                        quo_next   = mag_sh;
                        neg_next   = diff[16];
                        cnt_next   = CW'(AW);
                        state_next = S_DIV;
                    end
                end
                KIND_POINT:
                begin
                    acc_next  = ang;
                    last_next = cmd.last;
                    res_next.index     = cmd.index;
                    res_next.intensity = cmd.intensity;
                    res_next.range_mm  = cmd.range_mm;
                    res_next.angle     = 24'(ang);
                    res_next.head      = head_reg;
                    res_next.frame_no  = fno_reg;
                    res_next.count     = count_reg;
                    res_next.ts        = ts_reg;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_RUN;
            tp_reg    <= 1'b0;
            ov_reg    <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            tp_reg    <= tp_next;
            ov_reg    <= ov_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        dvs_reg   <= dvs_next;
        quo_reg   <= quo_next;
        acc_reg   <= acc_next;
        step_reg  <= step_next;
        neg_reg   <= neg_next;
        fmt0_reg  <= fmt0_next;
        head_reg  <= head_next;
        fno_reg   <= fno_next;
        count_reg <= count_next;
        ts_reg    <= ts_next;
        kind_reg  <= kind_next;
        last_reg  <= last_next;
        res_reg   <= res_next;
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = res_reg;
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;

endmodule

@@ hw/rtl/lidar_frame_parser_core.sv @@
// top level of the lidar datagram parser
// path: a request from an accepted byte goes through the request queue and then the output
//   register; a truncated error that follows another result of the same byte is shown after that result
// throughput: one byte per cycle; after a header of format 0 with more than one point the
//   back end runs its bit-serial step divider (S_DIV, then S_FIX), points wait in
//   the request queue and the input stalls once the queue is full
// reset: rst_n clears parser position, queue, divider control and the config registers
module lidar_frame_parser_core #(
    parameter int MAX_POINTS      = 512,
    parameter int ANGLE_FRAC_BITS = 8,
    parameter int QUEUE_DEPTH     = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    // configuration write channel
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_data,
    // byte stream in
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,    // byte_value
    input  logic         s_tlast,    // end_of_datagram
    // results out
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[2:0], point_index[11:3], intensity[27:12], range_mm[43:28],
    // angle_centideg[67:44], head_flag[71:68], frame_number[75:72],
    // point_count[85:76], timestamp_scaled[124:86], zero fill[127:125]
    output logic [127:0] m_tdata,
    output logic [1:0]   m_tuser,    // kind
    output logic         m_tlast     // last_point
);
    import lfp_pkg::*;

    cfg_t cfg_reg;
    cmd_t f_cmd, q_cmd;
    logic f_push, q_full, q_ne, b_pop;

    // config registers are always writable
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_PREAMBLE: cfg_reg.preamble <= cfg_data;
                CFG_DEVICE:   cfg_reg.device   <= cfg_data[3:0];
                CFG_FRAME:    cfg_reg.frame    <= cfg_data[3:0];
                default:      ;
            endcase
        end
    end

    // front end walks the datagram and turns bytes into requests
    lfp_front #(
        .MAX_POINTS(MAX_POINTS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .push     (f_push),
        .cmd      (f_cmd)
    );

    // decouples the byte side from divider stalls and output back pressure
    lfp_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (f_push),
        .din       (f_cmd),
        .pop       (b_pop),
        .dout      (q_cmd),
        .not_empty (q_ne),
        .full      (q_full)
    );

    // back end computes angles and drives the output register
    lfp_back #(
        .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (q_cmd),
        .cmd_valid (q_ne),
        .cmd_pop   (b_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // front never pushes into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        f_push |-> !q_full)
        else $error("request pushed into full queue");

    // back end only pops a present request
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        b_pop |-> q_ne)
        else $error("request popped from empty queue");

    // point results always carry an ok status
    a_point_status: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == KIND_POINT) |-> (m_tdata[2:0] == ST_OK))
        else $error("point result with error status");

endmodule
